// File: hdl/ptsf_pkg.sv
// ----------------------------------------------------------------------------
// Per-tenant statistics package
// Shared types and codes for the per-tenant statistics and fairness block.
// ----------------------------------------------------------------------------
package ptsf_pkg;

    typedef enum logic [2:0] {
        CMD_FINISH = 3'd0,
        CMD_SAMPLE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_INDEX  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_RATIO = 2'd1,
        SRC_BYTES = 2'd2
    } src_e;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [23:0] ONE_Q16 = 24'h010000;
    localparam int unsigned JAIN_FRAC = 16;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_TUPD,
        S_LATGO,
        S_LATWAIT,
        S_RATGO,
        S_RATWAIT,
        S_IRD,
        S_ILOAD,
        S_IMUL,
        S_IFIN,
        S_INUM,
        S_IDEN,
        S_IDIV,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] lat_sum;
        logic [47:0] byte_sum;
        logic [39:0] ratio_sum;
        logic [31:0] sample_count;
        logic [23:0] smoothed;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        count: 32'd0, lat_sum: 64'd0, byte_sum: 48'd0,
        ratio_sum: 40'd0, sample_count: 32'd0, smoothed: ONE_Q16
    };

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  user_id;
        logic [47:0] arrival_time;
        logic [47:0] finish_time;
        logic [31:0] xfer_bytes;
        logic [23:0] inst_ratio;
        logic [23:0] smooth_ratio;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] completed_count;
        logic [47:0] mean_latency;
        logic [47:0] byte_total;
        logic [23:0] ratio_avg;
        logic [23:0] ratio_smoothed;
        logic        has_samples;
        logic [16:0] jain_index;
        logic [1:0]  index_source;
    } rsp_t;

endpackage

// File: hdl/ptsf_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command for the statistics table.
// ----------------------------------------------------------------------------
interface ptsf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  user_id;
    logic [47:0] arrival_time;
    logic [47:0] finish_time;
    logic [31:0] xfer_bytes;
    logic [23:0] inst_ratio;
    logic [23:0] smooth_ratio;

    modport source (
        output valid, cmd, user_id, arrival_time, finish_time, xfer_bytes,
               inst_ratio, smooth_ratio,
        input  ready
    );
    modport sink (
        input  valid, cmd, user_id, arrival_time, finish_time, xfer_bytes,
               inst_ratio, smooth_ratio,
        output ready
    );
endinterface

// File: hdl/ptsf_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result of the statistics table.
// ----------------------------------------------------------------------------
interface ptsf_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] completed_count;
    logic [47:0] mean_latency;
    logic [47:0] byte_total;
    logic [23:0] ratio_avg;
    logic [23:0] ratio_smoothed;
    logic        has_samples;
    logic [16:0] jain_index;
    logic [1:0]  index_source;

    modport source (
        output valid, status, completed_count, mean_latency, byte_total,
               ratio_avg, ratio_smoothed, has_samples, jain_index, index_source,
        input  ready
    );
    modport sink (
        input  valid, status, completed_count, mean_latency, byte_total,
               ratio_avg, ratio_smoothed, has_samples, jain_index, index_source,
        output ready
    );
endinterface

// File: hdl/ptsf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hdl/ptsf_udiv.sv
// ----------------------------------------------------------------------------
// Unsigned divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptsf_udiv #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] dsr_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, dsr_reg}) : DEN_W'(trial);
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: hdl/per_tenant_stats_fairness_index.sv
// ----------------------------------------------------------------------------
// Per-tenant statistics and fairness index
// Tenant table with finish and fairness updates, reads, clear and Jain's index.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the req channel (valid/ready) and every command gives
//   exactly one result on the rsp channel. One command is worked on at a
//   time; req.ready is high while the block is idle, even if a result still
//   waits in the output register.
//   Finish, sample and read read the tenant entry from the table memory;
//   finish and sample write it back updated. Then each mean takes a pass of
//   the shared restoring divider when its count is nonzero.
//   The index command walks the table memory, reading each tenant and
//   squaring its byte count by shift-add, then runs shift-add for the two
//   wide products and a restoring division for the 17 quotient bits.
//   Clear writes the reset entry to every tenant, then returns its result.
//   After reset the same pass runs before the first request is taken.
//   When rsp.ready is low a finished result stays in the output register;
//   the next request is still taken and its result waits until the register
//   is free.
// ----------------------------------------------------------------------------
module per_tenant_stats_fairness_index #(
    parameter int MAX_USERS = 64,
    parameter int TIME_BITS = 48
) (
    input  logic clk,
    input  logic rst_n,
    ptsf_req_if.sink   req,
    ptsf_rsp_if.source rsp
);
    import ptsf_pkg::*;

    localparam int AW      = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int NB      = $clog2(MAX_USERS + 1);
    localparam int SUMS_W  = 24 + NB;
    localparam int SQS_W   = 48 + NB;
    localparam int SUMB_W  = 48 + NB;
    localparam int SQB_W   = 96 + NB;
    localparam int RW      = 2 * SUMB_W + 1;
    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [10:0] USERS_L = 11'(MAX_USERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_USERS - 1);
    localparam logic [47:0] TMASK =
        (TIME_BITS >= 48) ? {48{1'b1}} : 48'((64'd1 << TIME_BITS) - 64'd1);

    state_e state_reg, state_next;

    req_t   req_in;
    req_t   req_reg;
    entry_t entry_reg;
    rsp_t   res_reg;
    rsp_t   res_init;
    rsp_t   out_reg;
    logic   out_valid_reg;
    logic   out_load;

    logic [AW-1:0] clr_idx_reg;
    logic          clr_rsp_reg;
    logic [AW-1:0] walk_idx_reg;

    logic [NB-1:0]     n_s_reg;
    logic [SUMS_W-1:0] sum_s_reg;
    logic [SQS_W-1:0]  sq_s_reg;
    logic [NB-1:0]     n_b_reg;
    logic [SUMB_W-1:0] sum_b_reg;
    logic [SQB_W-1:0]  sq_b_reg;
    logic [47:0]       sm_prod_reg;

    logic [RW-1:0]     mcand_reg;
    logic [SUMB_W-1:0] mplier_reg;
    logic [RW-1:0]     acc_reg;
    logic [RW-1:0]     rem_reg;
    logic [16:0]       quo_reg;
    logic [4:0]        dcnt_reg;
    src_e              src_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quo;

    logic        accept;
    logic        in_range;
    logic        is_tenant;
    logic        walk_last;
    entry_t      upd;
    logic [47:0] t_arr;
    logic [47:0] t_fin;
    logic [47:0] lat;
    logic [32:0] cnt_sum;
    logic [64:0] lat_sum;
    logic [48:0] byte_sum;
    logic [40:0] rsum_sum;
    logic [32:0] scnt_sum;
    logic [SQS_W-1:0]  fin_sq_s;
    src_e              fin_src;
    logic [SUMB_W-1:0] sum_sel;
    logic [RW-1:0]     sq_sel;
    logic [SUMB_W-1:0] n_sel;
    logic [RW-1:0]     div_trial;
    logic              div_fits;

    ptsf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_USERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptsf_udiv #(
        .NUM_W (64),
        .DEN_W (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rd_entry = ram_rdata;

    assign req_in = '{
        cmd: req.cmd, user_id: req.user_id, arrival_time: req.arrival_time,
        finish_time: req.finish_time, xfer_bytes: req.xfer_bytes,
        inst_ratio: req.inst_ratio, smooth_ratio: req.smooth_ratio
    };

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);
    assign in_range  = {3'b000, req.user_id} < USERS_L;
    assign is_tenant = (req.cmd == CMD_FINISH) || (req.cmd == CMD_SAMPLE)
                    || (req.cmd == CMD_READ);
    assign walk_last = (walk_idx_reg == LAST_IDX);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        res_init        = '0;
        res_init.status = (is_tenant && !in_range) ? STATUS_RANGE : STATUS_OK;
    end

    // Entry update for finish and sample commands; a read keeps the entry.
    always_comb
    begin
        t_arr    = req_reg.arrival_time & TMASK;
        t_fin    = req_reg.finish_time & TMASK;
        lat      = (t_fin > t_arr) ? (t_fin - t_arr) : 48'd0;
        cnt_sum  = {1'b0, rd_entry.count} + 33'd1;
        lat_sum  = {1'b0, rd_entry.lat_sum} + {17'd0, lat};
        byte_sum = {1'b0, rd_entry.byte_sum} + {17'd0, req_reg.xfer_bytes};
        rsum_sum = {1'b0, rd_entry.ratio_sum} + {17'd0, req_reg.inst_ratio};
        scnt_sum = {1'b0, rd_entry.sample_count} + 33'd1;
        upd      = rd_entry;
        if (req_reg.cmd == CMD_FINISH)
        begin
            upd.count    = cnt_sum[32] ? {32{1'b1}} : cnt_sum[31:0];
            upd.lat_sum  = lat_sum[64] ? {64{1'b1}} : lat_sum[63:0];
            upd.byte_sum = byte_sum[48] ? {48{1'b1}} : byte_sum[47:0];
        end
        else if (req_reg.cmd == CMD_SAMPLE)
        begin
            upd.ratio_sum    = rsum_sum[40] ? {40{1'b1}} : rsum_sum[39:0];
            upd.sample_count = scnt_sum[32] ? {32{1'b1}} : scnt_sum[31:0];
            upd.smoothed     = req_reg.smooth_ratio;
        end
    end

    // Index selection: smoothed ratios first, byte counts as fallback.
    always_comb
    begin
        fin_sq_s = sq_s_reg + SQS_W'(sm_prod_reg);
        if ((n_s_reg != '0) && (fin_sq_s != '0))
        begin
            fin_src = SRC_RATIO;
        end
        else if (n_b_reg != '0)
        begin
            fin_src = SRC_BYTES;
        end
        else
        begin
            fin_src = SRC_NONE;
        end
        sum_sel = (fin_src == SRC_RATIO) ? SUMB_W'(sum_s_reg) : sum_b_reg;
        sq_sel  = (src_reg == SRC_RATIO) ? RW'(sq_s_reg) : RW'(sq_b_reg);
        n_sel   = (src_reg == SRC_RATIO) ? SUMB_W'(n_s_reg) : SUMB_W'(n_b_reg);
        div_trial = (dcnt_reg == 5'd0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
        div_fits  = div_trial >= acc_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = clr_rsp_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_e'(req.cmd))
                        CMD_FINISH, CMD_SAMPLE, CMD_READ:
                            state_next = in_range ? S_TUPD : S_DONE;
                        CMD_INDEX: state_next = S_IRD;
                        CMD_CLEAR: state_next = S_CLR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_TUPD:    state_next = S_LATGO;
            S_LATGO:   state_next = (entry_reg.count != '0) ? S_LATWAIT : S_RATGO;
            S_LATWAIT: state_next = div_done ? S_RATGO : S_LATWAIT;
            S_RATGO:
                state_next = (entry_reg.sample_count != '0) ? S_RATWAIT : S_DONE;
            S_RATWAIT: state_next = div_done ? S_DONE : S_RATWAIT;
            S_IRD:     state_next = S_ILOAD;
            S_ILOAD:   state_next = S_IMUL;
            S_IMUL:
            begin
                if (mplier_reg == '0)
                begin
                    state_next = walk_last ? S_IFIN : S_IRD;
                end
            end
            S_IFIN:    state_next = (fin_src == SRC_NONE) ? S_DONE : S_INUM;
            S_INUM:    state_next = (mplier_reg == '0) ? S_IDEN : S_INUM;
            S_IDEN:    state_next = (mplier_reg == '0) ? S_IDIV : S_IDEN;
            S_IDIV:    state_next = (dcnt_reg == 5'(JAIN_FRAC)) ? S_DONE : S_IDIV;
            S_DONE:    state_next = out_load ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Memory and divider controls
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = clr_idx_reg;
        ram_wdata    = ENTRY_RESET;
        ram_re       = 1'b0;
        ram_raddr    = walk_idx_reg;
        div_start    = 1'b0;
        div_dividend = entry_reg.lat_sum;
        div_divisor  = entry_reg.count;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_re    = accept;
                ram_raddr = AW'(req.user_id);
            end
            S_TUPD:
            begin
                ram_we    = (req_reg.cmd == CMD_FINISH) || (req_reg.cmd == CMD_SAMPLE);
                ram_waddr = AW'(req_reg.user_id);
                ram_wdata = upd;
            end
            S_LATGO:
            begin
                div_start = (entry_reg.count != '0);
            end
            S_RATGO:
            begin
                div_start    = (entry_reg.sample_count != '0);
                div_dividend = {24'd0, entry_reg.ratio_sum};
                div_divisor  = entry_reg.sample_count;
            end
            S_IRD:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            clr_rsp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            else if (accept && (req.cmd == CMD_CLEAR))
            begin
                clr_idx_reg <= '0;
                clr_rsp_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_reg        <= req_in;
                    res_reg        <= res_init;
                    walk_idx_reg   <= '0;
                    n_s_reg        <= '0;
                    sum_s_reg      <= '0;
                    sq_s_reg       <= '0;
                    n_b_reg        <= '0;
                    sum_b_reg      <= '0;
                    sq_b_reg       <= '0;
                    sm_prod_reg    <= '0;
                end
            end
            S_TUPD:
            begin
                entry_reg <= upd;
            end
            S_LATGO:
            begin
                res_reg.completed_count <= entry_reg.count;
                res_reg.byte_total      <= entry_reg.byte_sum;
                if (entry_reg.sample_count != '0)
                begin
                    res_reg.ratio_smoothed <= entry_reg.smoothed;
                    res_reg.has_samples    <= 1'b1;
                end
            end
            S_LATWAIT:
            begin
                if (div_done)
                begin
                    res_reg.mean_latency <= (div_quo[63:48] != '0) ? {48{1'b1}} : div_quo[47:0];
                end
            end
            S_RATWAIT:
            begin
                if (div_done)
                begin
                    res_reg.ratio_avg <= (div_quo[63:24] != '0) ? {24{1'b1}} : div_quo[23:0];
                end
            end
            S_IRD:
            begin
                // The previous tenant's ratio square is folded in here.
                sq_s_reg <= fin_sq_s;
            end
            S_ILOAD:
            begin
                if (rd_entry.sample_count != '0)
                begin
                    n_s_reg     <= n_s_reg + NB'(1);
                    sum_s_reg   <= sum_s_reg + SUMS_W'(rd_entry.smoothed);
                    sm_prod_reg <= rd_entry.smoothed * rd_entry.smoothed;
                end
                else
                begin
                    sm_prod_reg <= '0;
                end
                if (rd_entry.byte_sum != '0)
                begin
                    n_b_reg   <= n_b_reg + NB'(1);
                    sum_b_reg <= sum_b_reg + SUMB_W'(rd_entry.byte_sum);
                end
                mcand_reg  <= RW'(rd_entry.byte_sum);
                mplier_reg <= SUMB_W'(rd_entry.byte_sum);
            end
            S_IMUL:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                    begin
                        sq_b_reg <= sq_b_reg + mcand_reg[SQB_W-1:0];
                    end
                    mcand_reg  <= {mcand_reg[RW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SUMB_W-1:1]};
                end
                else
                begin
                    walk_idx_reg <= walk_idx_reg + AW'(1);
                end
            end
            S_IFIN:
            begin
                sq_s_reg              <= fin_sq_s;
                src_reg               <= fin_src;
                res_reg.index_source  <= fin_src;
                mcand_reg             <= RW'(sum_sel);
                mplier_reg            <= sum_sel;
                acc_reg               <= '0;
            end
            S_INUM:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[RW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SUMB_W-1:1]};
                end
                else
                begin
                    rem_reg    <= acc_reg;
                    acc_reg    <= '0;
                    mcand_reg  <= sq_sel;
                    mplier_reg <= n_sel;
                end
            end
            S_IDEN:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[RW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SUMB_W-1:1]};
                end
                else
                begin
                    dcnt_reg <= '0;
                    quo_reg  <= '0;
                end
            end
            S_IDIV:
            begin
                // The first step takes the integer bit, then 16 fraction bits.
                rem_reg  <= div_fits ? (div_trial - acc_reg) : div_trial;
                quo_reg  <= {quo_reg[15:0], div_fits};
                dcnt_reg <= dcnt_reg + 5'd1;
                if (dcnt_reg == 5'(JAIN_FRAC))
                begin
                    res_reg.jain_index <= {quo_reg[15:0], div_fits};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.completed_count = out_reg.completed_count;
    assign rsp.mean_latency    = out_reg.mean_latency;
    assign rsp.byte_total      = out_reg.byte_total;
    assign rsp.ratio_avg       = out_reg.ratio_avg;
    assign rsp.ratio_smoothed  = out_reg.ratio_smoothed;
    assign rsp.has_samples     = out_reg.has_samples;
    assign rsp.jain_index      = out_reg.jain_index;
    assign rsp.index_source    = out_reg.index_source;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !ram_we)
        else $error("table written while idle");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDIV && dcnt_reg != 5'd0) |-> (rem_reg < acc_reg))
        else $error("index remainder not below denominator");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented without a finished request");

    a_stall_holds_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("finished result dropped while output stalled");
endmodule
